/* rtl/bank_switch_mapper_scanline_irq_unit_defines.svh */
// assertion macros for the mapper rtl, included by bsm_core
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_UNIT_DEFINES_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define BSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mapper check failed");
// next-cycle implication, sampled on clk, off during reset
`define BSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mapper check failed");
`else
`define BSM_ASSERT_IMP(lbl, ante, cons)
`define BSM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/bsm_pkg.sv */
// types, codes and helpers shared by the mapper modules
package bsm_pkg;

  // item function codes
  localparam logic [1:0] FuncRead  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncTick  = 2'd2;

  // cpu register regions at 0x8000, 0xA000, 0xC000, 0xE000 (address bits 14:13)
  localparam logic [1:0] RegBank      = 2'd0;
  localparam logic [1:0] RegMirror    = 2'd1;
  localparam logic [1:0] RegIrqLatch  = 2'd2;
  localparam logic [1:0] RegIrqEnable = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgPrgSize     = 2'd0;
  localparam logic [1:0] CfgStartMirror = 2'd1;

  localparam logic [5:0] PrgSizeReset = 6'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [18:0] mapped;
    logic        irq;
  } result_t;

  // last fixed 8KB window, 2N-1 modulo 64
  function automatic logic [5:0] last_fixed(input logic [5:0] n);
    last_fixed = {n[4:0], 1'b0} - 6'd1;
  endfunction

  // second to last fixed 8KB window, 2N-2 modulo 64
  function automatic logic [5:0] second_fixed(input logic [5:0] n);
    second_fixed = {n[4:0], 1'b0} - 6'd2;
  endfunction

endpackage

/* rtl/bank_switch_mapper_scanline_irq_unit.sv */
// Bank-switching cartridge mapper with scanline interrupt counter. Each input
// transfer is a read, a write or a scanline tick and yields one result: the
// translated CHR, nametable, PRG or RAM offset (0x3F00-0x5FFF passes as is)
// and the pending irq flag after the item. One item is accepted every cycle
// unless out_stall backs up the pipe; a result passes the input register, then
// the decode/translate logic into the result register, and out_stall holds both
// registers. The configuration port is ready whenever no item moves into the
// result register, and should be written only while the block is idle.
module bank_switch_mapper_scanline_irq_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_cpu_or_ppu_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [18:0] out_mapped_address,
  output logic        out_irq_line,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bsm_pkg::*;

  logic    fire;
  logic    item_vld;
  item_t   item;
  result_t res;

  // config write waits while an item updates the state
  assign cfg_ready = ~fire;

  // input register
  bsm_in_stage u_in (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_func               (in_func),
    .in_cpu_or_ppu_address (in_cpu_or_ppu_address),
    .in_write_data         (in_write_data),
    .fire                  (fire),
    .vld                   (item_vld),
    .item                  (item)
  );

  // mapper state and translation
  bsm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .res       (res)
  );

  // result register
  bsm_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_vld             (item_vld),
    .res                (res),
    .out_stall          (out_stall),
    .fire               (fire),
    .out_valid          (out_valid),
    .out_mapped_address (out_mapped_address),
    .out_irq_line       (out_irq_line)
  );
endmodule

/* rtl/bsm_in_stage.sv */
// input register of the mapper pipeline
module bsm_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_func,
  input  logic [15:0]    in_cpu_or_ppu_address,
  input  logic [7:0]     in_write_data,
  input  logic           fire,
  output logic           vld,
  output bsm_pkg::item_t item
);
  import bsm_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  // hold the item only while it cannot move on
  assign in_stall = vld_r & ~fire;

  always_comb begin
    vld_nxt = vld_r;
    if (fire) begin
      vld_nxt = 1'b0;
    end
    if (in_valid && !in_stall) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.func <= in_func;
      item_r.addr <= in_cpu_or_ppu_address;
      item_r.data <= in_write_data;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;
endmodule

/* rtl/bsm_core.sv */
// mapper state, register decode, irq counter and address translation
`include "bank_switch_mapper_scanline_irq_unit_defines.svh"
module bsm_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bsm_pkg::item_t   item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [7:0]       cfg_wdata,
  output bsm_pkg::result_t res
);
  import bsm_pkg::*;

  logic [5:0] prg_size_r;
  logic [7:0] bank_r [8];
  logic [2:0] sel_r;
  logic       mode_r;
  logic       inv_r;
  logic [7:0] chr_r [8];
  logic [5:0] prg_r [4];
  logic       mir_r;
  logic [7:0] cnt_r;
  logic [7:0] latch_r;
  logic       en_r;
  logic       pend_r;

  // state as it stands after the current item
  logic [7:0] bank_nxt [8];
  logic [2:0] sel_nxt;
  logic       mode_nxt;
  logic       inv_nxt;
  logic [7:0] chr_nxt [8];
  logic [5:0] prg_nxt [4];
  logic       mir_nxt;
  logic [7:0] cnt_nxt;
  logic [7:0] latch_nxt;
  logic       en_nxt;
  logic       pend_nxt;

  logic        odd;
  logic [18:0] mapped;

  assign odd = item.addr[0];

  // register writes, window rebuild and scanline tick
  always_comb begin
    bank_nxt  = bank_r;
    sel_nxt   = sel_r;
    mode_nxt  = mode_r;
    inv_nxt   = inv_r;
    chr_nxt   = chr_r;
    prg_nxt   = prg_r;
    mir_nxt   = mir_r;
    cnt_nxt   = cnt_r;
    latch_nxt = latch_r;
    en_nxt    = en_r;
    pend_nxt  = pend_r;
    case (item.func)
      FuncWrite: begin
        if (item.addr[15]) begin
          case (item.addr[14:13])
            RegBank: begin
              if (odd) begin
                bank_nxt[sel_r] = item.data;
                // 2KB pair side, second bank forced odd
                chr_nxt[{inv_r, 2'd0}]  = bank_nxt[0] & 8'hFE;
                chr_nxt[{inv_r, 2'd1}]  = bank_nxt[0] | 8'h01;
                chr_nxt[{inv_r, 2'd2}]  = bank_nxt[1] & 8'hFE;
                chr_nxt[{inv_r, 2'd3}]  = bank_nxt[1] | 8'h01;
                chr_nxt[{~inv_r, 2'd0}] = bank_nxt[2];
                chr_nxt[{~inv_r, 2'd1}] = bank_nxt[3];
                chr_nxt[{~inv_r, 2'd2}] = bank_nxt[4];
                chr_nxt[{~inv_r, 2'd3}] = bank_nxt[5];
                if (mode_r) begin
                  prg_nxt[0] = second_fixed(prg_size_r);
                  prg_nxt[2] = bank_nxt[6][5:0];
                end else begin
                  prg_nxt[0] = bank_nxt[6][5:0];
                  prg_nxt[2] = second_fixed(prg_size_r);
                end
                prg_nxt[1] = bank_nxt[7][5:0];
                prg_nxt[3] = last_fixed(prg_size_r);
              end else begin
                sel_nxt  = item.data[2:0];
                mode_nxt = item.data[6];
                inv_nxt  = item.data[7];
              end
            end
            RegMirror: begin
              if (!odd) begin
                mir_nxt = item.data[0];
              end
            end
            RegIrqLatch: begin
              if (odd) begin
                cnt_nxt = 8'd0;
              end else begin
                latch_nxt = item.data;
              end
            end
            default: begin
              if (odd) begin
                en_nxt = 1'b1;
              end else begin
                en_nxt   = 1'b0;
                pend_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      FuncTick: begin
        cnt_nxt = (cnt_r != 8'd0) ? cnt_r - 8'd1 : latch_r;
        if (cnt_nxt == 8'd0 && en_r) begin
          pend_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // address translation on the updated state
  always_comb begin
    mapped = 19'd0;
    if (item.func == FuncRead || item.func == FuncWrite) begin
      if (item.addr[15:13] == 3'd0) begin
        mapped = {1'b0, chr_nxt[item.addr[12:10]], item.addr[9:0]};
      end else if (item.addr < 16'h3F00) begin
        // nametables, horizontal or vertical mirroring
        if (mir_nxt) begin
          mapped = {8'd0, item.addr[11], item.addr[9:0]};
        end else begin
          mapped = {8'd0, item.addr[10:0]};
        end
      end else if (item.addr < 16'h6000) begin
        mapped = {3'd0, item.addr};
      end else if (!item.addr[15]) begin
        mapped = {6'd0, item.addr[12:0]};
      end else begin
        mapped = {prg_nxt[item.addr[14:13]], item.addr[12:0]};
      end
    end
  end

  assign res.mapped = mapped;
  assign res.irq    = pend_nxt;

  // state update; the user must make configuration writes come only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_size_r <= PrgSizeReset;
      for (int i = 0; i < 8; i++) begin
        bank_r[i] <= 8'd0;
        chr_r[i]  <= 8'd0;
      end
      sel_r    <= 3'd0;
      mode_r   <= 1'b0;
      inv_r    <= 1'b0;
      prg_r[0] <= 6'd0;
      prg_r[1] <= 6'd1;
      prg_r[2] <= second_fixed(PrgSizeReset);
      prg_r[3] <= last_fixed(PrgSizeReset);
      mir_r    <= 1'b0;
      cnt_r    <= 8'd0;
      latch_r  <= 8'd0;
      en_r     <= 1'b0;
      pend_r   <= 1'b0;
    end else if (fire) begin
      bank_r  <= bank_nxt;
      sel_r   <= sel_nxt;
      mode_r  <= mode_nxt;
      inv_r   <= inv_nxt;
      chr_r   <= chr_nxt;
      prg_r   <= prg_nxt;
      mir_r   <= mir_nxt;
      cnt_r   <= cnt_nxt;
      latch_r <= latch_nxt;
      en_r    <= en_nxt;
      pend_r  <= pend_nxt;
    end else if (cfg_we) begin
      if (cfg_idx == CfgPrgSize) begin
        prg_size_r <= cfg_wdata[5:0];
        prg_r[0]   <= 6'd0;
        prg_r[1]   <= 6'd1;
        prg_r[2]   <= second_fixed(cfg_wdata[5:0]);
        prg_r[3]   <= last_fixed(cfg_wdata[5:0]);
      end
      if (cfg_idx == CfgStartMirror) begin
        mir_r <= cfg_wdata[0];
      end
    end
  end

  // last prg window always tracks the configured size
  `BSM_ASSERT_IMP(a_last_fixed, 1'b1, prg_r[3] == last_fixed(prg_size_r))
  // acknowledge write drops the pending flag
  `BSM_ASSERT_NXT(a_irq_ack, fire && item.func == FuncWrite && item.addr[15:13] == 3'b111 && !odd,
                  !pend_r)
  // pending only rises while the interrupt is enabled
  `BSM_ASSERT_IMP(a_irq_rise, $rose(pend_r), en_r)
endmodule

/* rtl/bsm_out_stage.sv */
// result register with stall handling
module bsm_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  bsm_pkg::result_t res,
  input  logic             out_stall,
  output logic             fire,
  output logic             out_valid,
  output logic [18:0]      out_mapped_address,
  output logic             out_irq_line
);
  import bsm_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  // an item moves on when the result slot is empty or being taken
  assign fire = in_vld & (~vld_r | ~out_stall);

  always_comb begin
    vld_nxt = vld_r & out_stall;
    if (fire) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = vld_r;
  assign out_mapped_address = res_r.mapped;
  assign out_irq_line       = res_r.irq;
endmodule
